>>> src/hfe_pkg.sv
// ----------------------------------------------------------------------------
// HDLC frame encoder package
// Shared constants, the job record that goes from front to back, the
// back-end phase type and the CRC-16/X.25 byte update.
// ----------------------------------------------------------------------------
package hfe_pkg;

  localparam logic [7:0]  FLAG_BYTE = 8'h7E;
  localparam logic [7:0]  ESC_BYTE  = 8'h7D;
  localparam logic [7:0]  ESC_FLAG  = 8'h5E;
  localparam logic [7:0]  ESC_ESC   = 8'h5D;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'h8408;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic        open;
    logic [7:0]  body;
    logic        last;
    logic [15:0] fcs;
  } hfe_job_t;

  typedef enum logic [2:0] {
    PH_OPEN,
    PH_BODY,
    PH_FCS_LO,
    PH_FCS_HI,
    PH_CLOSE
  } hfe_phase_t;

  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> src/hfe_front.sv
// ----------------------------------------------------------------------------
// HDLC frame encoder front end
// Accepts body bytes, tracks the open frame, runs the CRC and hands one job
// per byte to the queue.
// ----------------------------------------------------------------------------
module hfe_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              body_valid,
  output logic              body_stall,
  input  logic [7:0]        body_byte,
  input  logic              end_of_body,
  output logic              push,
  input  logic              push_ready,
  output hfe_pkg::hfe_job_t job
);
  import hfe_pkg::*;

  logic [15:0] crc;
  logic        inside_frame;
  logic [15:0] crc_start;
  logic [15:0] crc_new;

  assign body_stall = !push_ready;
  assign push       = body_valid && push_ready;
  assign crc_start  = inside_frame ? crc : CRC_INIT;
  assign crc_new    = crc_update(crc_start, body_byte);

  always_comb begin
    job.open = !inside_frame;
    job.body = body_byte;
    job.last = end_of_body;
    job.fcs  = ~crc_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc          <= CRC_INIT;
      inside_frame <= 1'b0;
    end else if (push) begin
      crc          <= end_of_body ? CRC_INIT : crc_new;
      inside_frame <= !end_of_body;
    end
  end

endmodule

>>> src/hfe_queue.sv
// ----------------------------------------------------------------------------
// HDLC frame encoder job queue
// Small register queue that decouples the front end from the line sequencer.
// ----------------------------------------------------------------------------
module hfe_queue #(
  parameter int DEPTH = hfe_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              push_ready,
  input  hfe_pkg::hfe_job_t push_job,
  output logic              head_valid,
  input  logic              pop,
  output hfe_pkg::hfe_job_t head_job
);
  import hfe_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  hfe_job_t        slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign push_ready = (count != CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> src/hfe_back.sv
// ----------------------------------------------------------------------------
// HDLC frame encoder line sequencer
// Walks a job through opening flag (new frame), stuffed body, stuffed FCS and
// closing flag (last byte), a byte per unstalled cycle, to an output register.
// ----------------------------------------------------------------------------
module hfe_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  hfe_pkg::hfe_job_t head_job,
  output logic              pop,
  output logic              line_valid,
  input  logic              line_stall,
  output logic [7:0]        line_byte,
  output logic              run_last,
  output logic              frame_end
);
  import hfe_pkg::*;

  hfe_phase_t phase;
  hfe_phase_t phase_next;
  hfe_phase_t eff_phase;
  logic       esc;
  logic       esc_next;
  logic       advance;
  logic [7:0] raw;
  logic [7:0] emit_byte;
  logic       seg_done;
  logic       job_done;
  logic       emit_end;

  assign advance   = head_valid && (!line_valid || !line_stall);
  assign eff_phase = (phase == PH_OPEN && !head_job.open) ? PH_BODY : phase;
  assign pop       = advance && job_done;

  always_comb begin
    raw       = head_job.body;
    emit_byte = FLAG_BYTE;
    seg_done  = 1'b1;
    case (eff_phase)
      PH_BODY:   raw = head_job.body;
      PH_FCS_LO: raw = head_job.fcs[7:0];
      PH_FCS_HI: raw = head_job.fcs[15:8];
      default:   raw = FLAG_BYTE;
    endcase
    if (eff_phase == PH_OPEN || eff_phase == PH_CLOSE) begin
      emit_byte = FLAG_BYTE;
    end else if (esc) begin
      emit_byte = (raw == FLAG_BYTE) ? ESC_FLAG : ESC_ESC;
    end else if (raw inside {FLAG_BYTE, ESC_BYTE}) begin
      emit_byte = ESC_BYTE;
      seg_done  = 1'b0;
    end else begin
      emit_byte = raw;
    end
    emit_end = (eff_phase == PH_CLOSE);
    job_done = seg_done && (emit_end || (eff_phase == PH_BODY && !head_job.last));
  end

  always_comb begin
    phase_next = phase;
    esc_next   = esc;
    if (advance) begin
      esc_next = !seg_done;
      if (job_done) begin
        phase_next = PH_OPEN;
      end else if (seg_done) begin
        case (eff_phase)
          PH_OPEN:   phase_next = PH_BODY;
          PH_BODY:   phase_next = PH_FCS_LO;
          PH_FCS_LO: phase_next = PH_FCS_HI;
          PH_FCS_HI: phase_next = PH_CLOSE;
          default:   phase_next = PH_OPEN;
        endcase
      end else begin
        phase_next = eff_phase;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_OPEN;
      esc        <= 1'b0;
      line_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      esc   <= esc_next;
      if (advance) begin
        line_valid <= 1'b1;
      end else if (!line_stall) begin
        line_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      line_byte <= emit_byte;
      run_last  <= job_done;
      frame_end <= emit_end;
    end
  end

endmodule

>>> src/hdlc_frame_encoder_crc16_x25_unit.sv
// ----------------------------------------------------------------------------
// HDLC frame encoder with CRC-16/X.25
// Frames a byte stream: opening flag, byte-stuffed body, stuffed inverted
// FCS (low byte first) and closing flag.
//
//   channel | handshake               | payload
//   --------+-------------------------+----------------------------------
//   body    | body_valid / body_stall | body_byte, end_of_body
//   line    | line_valid / line_stall | line_byte, run_last, frame_end
//
// One line byte leaves per unstalled cycle. A body byte gives its data byte,
// led by an escape if stuffed and by an opening flag if it opens a frame; the
// last adds the stuffed FCS low and high bytes and the closing flag. The front
// end takes one body byte a cycle while the QUEUE_DEPTH-entry queue has room.
// Reset empties the queue, closes any frame and loads the CRC with 0xFFFF.
// ----------------------------------------------------------------------------
module hdlc_frame_encoder_crc16_x25_unit #(
  parameter int QUEUE_DEPTH = hfe_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       body_valid,
  output logic       body_stall,
  input  logic [7:0] body_byte,
  input  logic       end_of_body,
  output logic       line_valid,
  input  logic       line_stall,
  output logic [7:0] line_byte,
  output logic       run_last,
  output logic       frame_end
);
  import hfe_pkg::*;

  logic     push;
  logic     push_ready;
  hfe_job_t push_job;
  logic     head_valid;
  logic     pop;
  hfe_job_t head_job;

  hfe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .body_valid (body_valid),
    .body_stall (body_stall),
    .body_byte  (body_byte),
    .end_of_body(end_of_body),
    .push       (push),
    .push_ready (push_ready),
    .job        (push_job)
  );

  hfe_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_ready(push_ready),
    .push_job  (push_job),
    .head_valid(head_valid),
    .pop       (pop),
    .head_job  (head_job)
  );

  hfe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head_job  (head_job),
    .pop       (pop),
    .line_valid(line_valid),
    .line_stall(line_stall),
    .line_byte (line_byte),
    .run_last  (run_last),
    .frame_end (frame_end)
  );

endmodule
